// ----- src/avnsd_pkg.sv -----
// ----------------------------------------------------------------------------
// avnsd_pkg
// Shared widths, constants and stage types of the dithered requantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package avnsd_pkg;

	// field widths
	localparam int SampleW  = 32;
	localparam int GainW    = 30;
	localparam int PcmW     = 16;
	localparam int ErrW     = 32;
	localparam int ProdW    = 63;
	localparam int AccW     = 36;
	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 32;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegVolumeGain   = 4'd0;
	localparam logic [CfgIdxW-1:0] RegDuplicateMono = 4'd1;

	// dither generator
	localparam logic [31:0] LcgMul = 32'h0019660d;
	localparam logic [31:0] LcgAdd = 32'h3c6ef35f;

	// 32-bit saturation limits
	localparam logic signed [ErrW-1:0] ErrMax = 32'sh7fffffff;
	localparam logic signed [ErrW-1:0] ErrMin = 32'sh80000000;

	// scaled sample leaving the gain pipeline
	typedef struct packed {
		logic                   valid;
		logic signed [ErrW-1:0] x;
	} scaled_t;

	// quantized result entering the output register
	typedef struct packed {
		logic                   valid;
		logic signed [PcmW-1:0] pcm;
	} result_t;

endpackage

`default_nettype wire

// ----- src/avnsd_intf.sv -----
// ----------------------------------------------------------------------------
// avnsd channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface avnsd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] input_sample;

	modport source (output valid, output input_sample, input ready);
	modport sink   (input valid, input input_sample, output ready);
endinterface

interface avnsd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pcm_value;
	logic               last_of_run;

	modport source (output valid, output pcm_value, output last_of_run, input ready);
	modport sink   (input valid, input pcm_value, input last_of_run, output ready);
endinterface

interface avnsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  reg_index;
	logic [31:0] reg_data;

	modport source (output valid, output reg_index, output reg_data, input ready);
	modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ----- src/audio_volume_noise_shaped_dither_top.sv -----
// ----------------------------------------------------------------------------
// audio_volume_noise_shaped_dither_top
// Volume scaling, noise-shaped dither and requantization to 16-bit PCM.
// ----------------------------------------------------------------------------
//  channel   dir   payload                        accepted when
//  samples   in    input_sample[31:0] signed      valid & ready
//  results   out   pcm_value[15:0], last_of_run   valid & ready
//  cfg       in    reg_index[3:0], reg_data[31:0] valid & ready (ready tied 1)
//
//  One item per cycle outside duplicate mode while the output is not stalled.
//  In duplicate mode each item holds the result register until it has been sent twice.
//  Reset clears the error taps, the current dither word and the pipeline valids.
//  A stalled output backs up through the stages to samples.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_volume_noise_shaped_dither_top import avnsd_pkg::*; #(
	parameter int OUTPUT_BITS   = 16,
	parameter int FRACTION_BITS = 28
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	avnsd_in_if.sink    samples,
	avnsd_out_if.source results,
	avnsd_cfg_if.sink   cfg
);

	localparam logic [GainW-1:0] GainReset = GainW'(longint'(1) << FRACTION_BITS);

	logic [GainW-1:0]       gain_q;
	logic                   dup_q;
	scaled_t                scaled;
	result_t                res;
	logic                   up_ready;
	logic signed [PcmW-1:0] pcm;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
			dup_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				RegVolumeGain:    gain_q <= cfg.reg_data[GainW-1:0];
				RegDuplicateMono: dup_q  <= cfg.reg_data[0];
				default: ;
			endcase
		end
	end

	avnsd_gain #(.FRACTION_BITS(FRACTION_BITS)) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.gain     (gain_q),
		.dn_ready (up_ready),
		.scaled   (scaled)
	);

	avnsd_shaper #(
		.FRACTION_BITS (FRACTION_BITS),
		.OUTPUT_BITS   (OUTPUT_BITS)
	) u_shaper (
		.clk    (clk),
		.arst_n (arst_n),
		.scaled (scaled),
		.fire   (scaled.valid && up_ready),
		.pcm    (pcm)
	);

	assign res.valid = scaled.valid;
	assign res.pcm   = pcm;

	avnsd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.dup      (dup_q),
		.up_ready (up_ready),
		.results  (results)
	);

endmodule

`default_nettype wire

// ----- src/avnsd_gain.sv -----
// ----------------------------------------------------------------------------
// avnsd_gain
// Input register, volume multiply, scale toward zero and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module avnsd_gain import avnsd_pkg::*; #(
	parameter int FRACTION_BITS = 28
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	avnsd_in_if.sink              samples,
	input  wire logic [GainW-1:0] gain,
	input  wire logic             dn_ready,
	output scaled_t               scaled
);

	localparam logic signed [ProdW-1:0] OneM1 =
		ProdW'((longint'(1) << FRACTION_BITS) - 1);

	logic                     v_s1, v_s2, v_s3;
	logic                     rdy_s1, rdy_s2, rdy_s3;
	logic signed [SampleW-1:0] sample_s1;
	logic signed [ProdW-1:0]  prod_s2;
	logic signed [ErrW-1:0]   x_s3;
	logic signed [ProdW-1:0]  prod, adj, quo;
	logic                     fits;
	logic signed [ErrW-1:0]   sat;

	// stall chain: a stage moves when it is empty or its successor moves
	assign rdy_s3 = !v_s3 || dn_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign samples.ready = rdy_s1;

	// signed sample times unsigned gain
	assign prod = $signed(sample_s1) * $signed({1'b0, gain});

	// divide by the unit, truncating toward zero, then saturate to 32 bits
	assign adj  = prod_s2 + (prod_s2[ProdW-1] ? OneM1 : '0);
	assign quo  = adj >>> FRACTION_BITS;
	assign fits = (quo[ProdW-1:ErrW-1] == {(ProdW-ErrW+1){quo[ErrW-1]}});
	assign sat  = fits ? quo[ErrW-1:0] : (quo[ProdW-1] ? ErrMin : ErrMax);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= samples.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (samples.valid && rdy_s1) sample_s1 <= samples.input_sample;
		if (v_s1 && rdy_s2)          prod_s2   <= prod;
		if (v_s2 && rdy_s3)          x_s3      <= sat;
	end

	assign scaled.valid = v_s3;
	assign scaled.x     = x_s3;

endmodule

`default_nettype wire

// ----- src/avnsd_shaper.sv -----
// ----------------------------------------------------------------------------
// avnsd_shaper
// Error feedback, dither, clipping and quantization with the shaping state.
// ----------------------------------------------------------------------------
`default_nettype none

module avnsd_shaper import avnsd_pkg::*; #(
	parameter int FRACTION_BITS = 28,
	parameter int OUTPUT_BITS   = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire scaled_t                scaled,
	input  wire logic                   fire,
	output logic signed [PcmW-1:0]      pcm
);

	// quantizer step is 2^Sh
	localparam int Sh     = (FRACTION_BITS + 1 - OUTPUT_BITS) > 0 ?
		(FRACTION_BITS + 1 - OUTPUT_BITS) : 0;
	localparam int BiasSh = Sh > 0 ? Sh - 1 : 0;
	localparam logic [31:0] Mask32 = 32'((longint'(1) << Sh) - 1);
	localparam logic [AccW-1:0] MaskW = AccW'(Mask32);
	localparam logic signed [AccW-1:0] Bias =
		Sh > 0 ? AccW'(longint'(1) << BiasSh) : '0;
	localparam logic signed [AccW-1:0] VMax =
		AccW'((longint'(1) << FRACTION_BITS) - 1);
	localparam logic signed [AccW-1:0] VMin =
		AccW'(-(longint'(1) << FRACTION_BITS));

	logic signed [ErrW-1:0] e_new_q, e_mid_q, e_old_q;
	logic [31:0]            seed_q, nxt_q;
	logic [31:0]            lcg;
	logic signed [AccW-1:0] sum, dif, o, oc, xc, oq, qs;
	logic signed [ErrW:0]   half_sum;
	logic signed [ErrW-1:0] err;

	// feedback: newest - middle + oldest
	assign sum = AccW'(scaled.x) + AccW'(e_new_q) - AccW'(e_mid_q) + AccW'(e_old_q);

	// dither difference of two successive words; next word kept one ahead
	assign dif = $signed(AccW'(nxt_q & Mask32)) - $signed(AccW'(seed_q & Mask32));
	assign lcg = nxt_q * LcgMul + LcgAdd;
	assign o   = sum + Bias + dif;

	// clip to unit range
	always_comb begin
		oc = o;
		xc = sum;
		priority if (o > VMax) begin
			oc = VMax;
			if (sum > VMax) xc = VMax;
		end else if (o < VMin) begin
			oc = VMin;
			if (sum < VMin) xc = VMin;
		end else begin
			oc = o;
		end
	end

	// round down to a step, new error, scaled result
	assign oq  = oc & ~MaskW;
	assign err = ErrW'(xc - oq);
	assign qs  = oq >>> Sh;
	assign pcm = qs[PcmW-1:0];

	// halving toward zero for the middle tap
	assign half_sum = (ErrW+1)'(e_new_q) + (ErrW+1)'(e_new_q[ErrW-1]);

	// shaping state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_new_q <= '0;
			e_mid_q <= '0;
			e_old_q <= '0;
			seed_q  <= '0;
			nxt_q   <= LcgAdd;
		end else if (fire) begin
			e_new_q <= err;
			e_mid_q <= ErrW'(half_sum >>> 1);
			e_old_q <= e_mid_q;
			seed_q  <= nxt_q;
			nxt_q   <= lcg;
		end
	end

endmodule

`default_nettype wire

// ----- src/avnsd_out.sv -----
// ----------------------------------------------------------------------------
// avnsd_out
// Result register; repeats each result once more in duplicate mode.
// ----------------------------------------------------------------------------
`default_nettype none

module avnsd_out import avnsd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire result_t res,
	input  wire logic    dup,
	output logic         up_ready,
	avnsd_out_if.source  results
);

	logic                   v_q, dup_q, phase_q;
	logic signed [PcmW-1:0] pcm_q;
	logic                   last;

	// the first of a duplicated pair is not last
	assign last     = !(dup_q && !phase_q);
	assign up_ready = !v_q || (results.ready && last);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= 1'b0;
			dup_q   <= 1'b0;
			phase_q <= 1'b0;
		end else if (up_ready) begin
			v_q     <= res.valid;
			dup_q   <= dup;
			phase_q <= 1'b0;
		end else if (results.ready) begin
			phase_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (up_ready && res.valid) pcm_q <= res.pcm;
	end

	assign results.valid       = v_q;
	assign results.pcm_value   = pcm_q;
	assign results.last_of_run = last;

endmodule

`default_nettype wire

// ----- src/avnsd_checker.sv -----
// ----------------------------------------------------------------------------
// avnsd_checker
// Port-level checks of the requantizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module avnsd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_pcm,
	input wire logic        out_last,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pcm) && $stable(out_last))
		else $error("result changed while stalled");

	// the first of a duplicated pair is followed by its twin
	a_dup_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_last && $stable(out_pcm))
		else $error("duplicate result missing or different");

	// with the result register empty the pipeline cannot be stalled
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind audio_volume_noise_shaped_dither_top avnsd_checker u_avnsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_pcm   (results.pcm_value),
	.out_last  (results.last_of_run),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

`default_nettype wire

// ----- tb/tb_audio_volume_noise_shaped_dither_top.sv -----
// ----------------------------------------------------------------------------
// tb_audio_volume_noise_shaped_dither_top
// Self-checking bench for the dithered volume requantizer. A queue-fed driver
// offers samples with random gaps. A clocked monitor stalls at random and
// checks every PCM item against a cycle-free model of the gain, error
// feedback, LCG dither, clipping and quantization. The run walks through
// several gain and duplicate-mode settings, extremes included.
// ----------------------------------------------------------------------------
module tb_audio_volume_noise_shaped_dither_top;
	import avnsd_pkg::*;

	localparam int OutBits      = 16;
	localparam int FracBits     = 28;
	localparam int QShift       = (FracBits + 1 - OutBits > 0) ? FracBits + 1 - OutBits : 0;
	localparam longint Unit     = longint'(1) <<< FracBits;
	localparam longint VMax     = Unit - 1;
	localparam longint VMin     = -Unit;
	localparam longint QMask    = (longint'(1) <<< QShift) - 1;
	localparam longint QBias    = (QShift > 0) ? (longint'(1) <<< (QShift - 1)) : 0;
	localparam int SettleCycles = 8;
	localparam int HoldLen      = 120;
	localparam int IdleLimit    = 2000;
	localparam int RandPhases   = 8;
	localparam int PhaseItems   = 154;

	typedef struct packed {
		logic signed [PcmW-1:0] pcm;
		logic                   last;
	} pcm_item_t;

	logic clk = 1'b0;
	logic arst_n;

	avnsd_in_if  smp_if ();
	avnsd_out_if res_if ();
	avnsd_cfg_if cfg_if ();

	audio_volume_noise_shaped_dither_top #(
		.OUTPUT_BITS  (OutBits),
		.FRACTION_BITS(FracBits)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(smp_if),
		.results(res_if),
		.cfg    (cfg_if)
	);

	always #2 clk = ~clk;

	// shadow of the block's registers and state
	logic        [GainW-1:0] gain_shadow;
	logic                    dup_shadow;
	logic signed [ErrW-1:0]  err_new, err_mid, err_old;
	logic        [31:0]      dither_word;

	logic signed [SampleW-1:0] samples_pending[$];
	pcm_item_t                 pcm_expected[$];

	int  mismatch_count = 0;
	int  src_gap, snk_stall, hold_cnt;
	int  hold_req = 0;
	int  hold_seen;
	bit  src_gap_en = 1'b1;
	bit  snk_stall_en = 1'b1;
	int  idle_cycles;

	// Gain, three-tap error feedback, dither, clip and requantize one sample.
	function automatic logic signed [PcmW-1:0] requantize(input logic signed [SampleW-1:0] smp);
		longint      x, o, e0, diff, q;
		logic [31:0] nxt;
		logic [31:0] mask32;
		mask32 = QMask[31:0];
		x = (longint'(smp) * longint'(gain_shadow)) / Unit;
		if (x > longint'(ErrMax))
			x = longint'(ErrMax);
		else if (x < longint'(ErrMin))
			x = longint'(ErrMin);
		e0 = longint'(err_new);
		x = x + e0 - longint'(err_mid) + longint'(err_old);
		err_old = err_mid;
		diff = e0 / 2;
		err_mid = diff[31:0];
		nxt = dither_word * LcgMul + LcgAdd;
		o = x + QBias + longint'(nxt & mask32) - longint'(dither_word & mask32);
		dither_word = nxt;
		if (o > VMax) begin
			o = VMax;
			if (x > VMax)
				x = VMax;
		end else if (o < VMin) begin
			o = VMin;
			if (x < VMin)
				x = VMin;
		end
		o = o & ~QMask;
		diff = x - o;
		err_new = diff[31:0];
		q = o >>> QShift;
		return q[PcmW-1:0];
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [SampleW-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $signed($urandom_range(0, 32'h1fffffff)) - 32'sh10000000;
		else if (r == 6)
			return $signed($urandom);
		else if (r == 7)
			return $signed($urandom_range(0, 40000)) - 32'sd20000;
		else if (r == 8)
			return $urandom_range(0, 1) ? 32'sh10000000 + $signed($urandom_range(0, 9000))
				: -32'sh10000000 - $signed($urandom_range(0, 9000));
		case ($urandom_range(0, 3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	// sample driver: accepted items go through the model into the store
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_if.valid <= 1'b0;
			smp_if.input_sample <= '0;
			src_gap <= 0;
		end else begin
			if (smp_if.valid && smp_if.ready) begin
				logic signed [PcmW-1:0] pcm;
				pcm = requantize(smp_if.input_sample);
				if (dup_shadow) begin
					pcm_expected.push_back('{pcm: pcm, last: 1'b0});
					pcm_expected.push_back('{pcm: pcm, last: 1'b1});
				end else begin
					pcm_expected.push_back('{pcm: pcm, last: 1'b1});
				end
			end
			if (!smp_if.valid || smp_if.ready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					smp_if.valid <= 1'b0;
				end else if (samples_pending.size() != 0) begin
					smp_if.valid <= 1'b1;
					smp_if.input_sample <= samples_pending.pop_front();
					if (src_gap_en && $urandom_range(0, 3) == 0)
						src_gap <= pick_gap();
				end else begin
					smp_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random stalls, requested long hold-offs, item check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			snk_stall <= 0;
			hold_cnt <= 0;
			hold_seen <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (pcm_expected.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected item: pcm_value=%0d last_of_run=%0b",
							res_if.pcm_value, res_if.last_of_run);
				end else begin
					pcm_item_t want;
					want = pcm_expected.pop_front();
					if (res_if.pcm_value !== want.pcm || res_if.last_of_run !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: pcm_value exp %0d got %0d, last_of_run exp %0b got %0b",
								want.pcm, res_if.pcm_value, want.last, res_if.last_of_run);
					end
				end
			end
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				res_if.ready <= 1'b0;
			end else if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_cnt <= HoldLen;
				res_if.ready <= 1'b0;
			end else if (snk_stall != 0) begin
				snk_stall <= snk_stall - 1;
				res_if.ready <= 1'b0;
			end else if (snk_stall_en && $urandom_range(0, 3) == 0) begin
				snk_stall <= pick_gap() - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.reg_data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == RegVolumeGain)
			gain_shadow = data[GainW-1:0];
		else if (idx == RegDuplicateMono)
			dup_shadow = data[0];
	endtask

	// wait until every sample is taken and every expected item has come
	task automatic wait_drained();
		do @(negedge clk); while (samples_pending.size() != 0 || smp_if.valid
			|| pcm_expected.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// new gain and duplicate setting, written while the block is idle
	task automatic set_mode(input logic [GainW-1:0] gain, input logic dup);
		wait_drained();
		write_reg(RegVolumeGain, {2'($urandom_range(0, 3)), gain});
		write_reg(RegDuplicateMono, {31'($urandom), dup});
		@(negedge clk);
	endtask

	initial begin
		logic [GainW-1:0] gain;
		smp_if.valid = 1'b0;
		smp_if.input_sample = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.reg_index = '0;
		cfg_if.reg_data = '0;
		gain_shadow = GainW'(1) << FracBits;
		dup_shadow = 1'b0;
		err_new = '0;
		err_mid = '0;
		err_old = '0;
		dither_word = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: unity gain, field extremes, clip edges, zero run
		set_mode(GainW'(1) << FracBits, 1'b0);
		samples_pending = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
			32'sh0fffffff, -32'sh10000000, 32'sh10000000, 32'sh08000000, -32'sh08000000,
			32'sd4096, -32'sd8192, 32'sh55555555, 32'shaaaaaaaa, 32'sd0, 32'sd0};

		// full-scale register gain: product saturation, duplicate mode
		set_mode('1, 1'b1);
		samples_pending = '{32'sh7fffffff, 32'sh80000000, 32'sh01000000, -32'sh01000000};

		// zero gain, then nominal top gain
		set_mode('0, 1'b0);
		samples_pending = '{32'sh7fffffff, -32'sd1};
		set_mode(GainW'(1) << (FracBits + 1), 1'b1);
		samples_pending = '{32'sh0fffffff, -32'sh10000000};

		// random phases across settings and idling patterns
		for (int p = 0; p < RandPhases; p++) begin
			case (p)
				0: gain = GainW'(1) << FracBits;
				1: gain = GainW'($urandom_range(0, 1 << 29));
				2: gain = GainW'(1) << (FracBits + 1);
				3: gain = '1;
				4: gain = GainW'($urandom_range(1 << 27, 1 << 29));
				5: gain = '0;
				6: gain = GainW'($urandom_range(0, 32'h3fffffff));
				default: gain = (GainW'(1) << FracBits) - 1;
			endcase
			set_mode(gain, p[0] ^ (p > 4));
			// phases 2 and 4 keep the sender busy; phase 4 has no idling at all
			src_gap_en = !(p == 2 || p == 4);
			snk_stall_en = (p != 4);
			if (p == 2 || p == 6)
				hold_req++;
			for (int n = 0; n < PhaseItems; n++) begin
				// sender pauses mid-phase until the block has drained
				if (p == 5 && n == PhaseItems / 2)
					wait_drained();
				samples_pending.push_back(rand_sample());
			end
		end

		wait_drained();
		if (mismatch_count == 0 && pcm_expected.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
